/* sv/ppgc_pkg.sv */
// shared types, constants and helpers for the polar pose go-to-goal controller
package ppgc_pkg;

    // coordinate guard bits, cordic datapath widths and stage count
    localparam int GUARD         = 8;
    localparam int XY_W          = 28;
    localparam int ANG_W         = 16;
    localparam int CORDIC_STAGES = 16;

    // reciprocal of the cordic gain in Q0.16, pi in Q29 split in two halves
    localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
    localparam logic [30:0] PI_Q29       = 31'd1686629713;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_GOAL_X          = 3'd0,
        REG_GOAL_Y          = 3'd1,
        REG_GOAL_HEADING    = 3'd2,
        REG_GAIN_RHO        = 3'd3,
        REG_GAIN_ALPHA      = 3'd4,
        REG_GAIN_BETA       = 3'd5,
        REG_DISTANCE_MARGIN = 3'd6,
        REG_HEADING_MARGIN  = 3'd7
    } t_reg_idx;

    // side data that rides along the cordic pipeline
    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] beta;
        logic               zero;
    } t_side;

    // atan(2^-i), 2^32 = 2*pi
    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // arctangent entry rounded to the angle width
    function automatic logic [ANG_W-1:0] atan_ang(input int idx);
        logic [32:0] t;
        t = {1'b0, ATAN_TAB[idx]} + (33'd1 << (31 - ANG_W));
        return t[32-ANG_W +: ANG_W];
    endfunction

    // saturate to 16 bit signed
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

/* sv/ppgc_cordic.sv */
// pipelined cordic vectoring: pre-rotation plus one micro-rotation per stage
module ppgc_cordic (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [16:0]           i_dx,
    input  logic signed [16:0]           i_dy,
    input  ppgc_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic signed [ppgc_pkg::XY_W-1:0] o_x,
    output logic [ppgc_pkg::ANG_W-1:0]   o_z,
    output ppgc_pkg::t_side              o_side
);
    import ppgc_pkg::*;

    logic                    r_v [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  r_x [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  r_y [CORDIC_STAGES+1];
    logic [ANG_W-1:0]        r_z [CORDIC_STAGES+1];
    t_side                   r_s [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  n_x0;
    logic signed [XY_W-1:0]  n_y0;

    // scale by guard bits, turn by pi for a left half-plane vector
    always_comb begin
        n_x0 = XY_W'(i_dx) <<< GUARD;
        n_y0 = XY_W'(i_dy) <<< GUARD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_s[0] <= i_side;
        if (i_dx < 0) begin
            r_x[0] <= -n_x0;
            r_y[0] <= -n_y0;
            r_z[0] <= ANG_W'(1) << (ANG_W - 1);
        end else begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= '0;
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic [ANG_W-1:0] A = atan_ang(i);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            r_s[i+1] <= r_s[i];
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + A;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - A;
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES];
    assign o_x     = r_x[CORDIC_STAGES];
    assign o_z     = r_z[CORDIC_STAGES];
    assign o_side  = r_s[CORDIC_STAGES];

endmodule

/* sv/polar_pose_go_to_goal_controller.sv */
// top level: polar go-to-goal pose controller with a cordic pipeline
// throughput: one pose per cycle, set by the fully unrolled 16-stage cordic
// o_busy stays low; results always leave on the strobe, no stall
// synchronous active-low reset clears valids and restores register defaults
module polar_pose_go_to_goal_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    output logic               o_valid,
    output logic signed [15:0] o_linear_speed,
    output logic signed [15:0] o_angular_rate,
    output logic               o_arrived,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import ppgc_pkg::*;

    // configuration registers
    logic signed [15:0] r_goal_x, r_goal_y, r_goal_heading;
    logic signed [15:0] r_gain_rho, r_gain_alpha, r_gain_beta;
    logic [15:0]        r_distance_margin;
    logic [14:0]        r_heading_margin;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // config write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x          <= 16'sd0;
            r_goal_y          <= 16'sd0;
            r_goal_heading    <= 16'sd0;
            r_gain_rho        <= 16'sd614;
            r_gain_alpha      <= 16'sd1638;
            r_gain_beta       <= -16'sd307;
            r_distance_margin <= 16'd51;
            r_heading_margin  <= 15'd1043;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GOAL_X:          r_goal_x          <= i_cfg_data;
                REG_GOAL_Y:          r_goal_y          <= i_cfg_data;
                REG_GOAL_HEADING:    r_goal_heading    <= i_cfg_data;
                REG_GAIN_RHO:        r_gain_rho        <= i_cfg_data;
                REG_GAIN_ALPHA:      r_gain_alpha      <= i_cfg_data;
                REG_GAIN_BETA:       r_gain_beta       <= i_cfg_data;
                REG_DISTANCE_MARGIN: r_distance_margin <= i_cfg_data;
                REG_HEADING_MARGIN:  r_heading_margin  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // stage a: goal vector, heading error, pose-at-goal flag
    logic               r_a_v;
    logic signed [16:0] r_a_dx, r_a_dy;
    t_side              r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_start && !o_busy;
        end
        r_a_dx           <= 17'(r_goal_x) - 17'(i_pose_x);
        r_a_dy           <= 17'(r_goal_y) - 17'(i_pose_y);
        r_a_side.heading <= i_pose_heading;
        r_a_side.beta    <= r_goal_heading - i_pose_heading;
        r_a_side.zero    <= (r_goal_x == i_pose_x) && (r_goal_y == i_pose_y);
    end

    logic                   c_v;
    logic signed [XY_W-1:0] c_x;
    logic [ANG_W-1:0]       c_z;
    t_side                  c_side;
    t_side                  c_side_in;

    assign c_side_in = r_a_side;

    ppgc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .i_dx    (r_a_dx),
        .i_dy    (r_a_dy),
        .i_side  (c_side_in),
        .o_valid (c_v),
        .o_x     (c_x),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    // stage d: gain compensation product, bearing error
    logic               r_d_v;
    logic signed [44:0] r_d_prod;
    logic signed [15:0] r_d_alpha, r_d_beta;
    logic signed [15:0] n_bearing;

    assign n_bearing = c_side.zero ? 16'sd0 : $signed(c_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= c_v;
        end
        r_d_prod  <= c_side.zero ? 45'sd0 : 45'(c_x) * 45'($signed(INV_GAIN_Q16));
        r_d_alpha <= n_bearing - c_side.heading;
        r_d_beta  <= c_side.beta;
    end

    // stage e: distance rounding, arrival test, angle products
    logic               r_e_v, r_e_arrived;
    logic [17:0]        r_e_dist;
    logic signed [31:0] r_e_pa, r_e_pb;
    logic signed [44:0] n_dist_w;
    logic [17:0]        n_dist;
    logic [15:0]        n_abs_beta;

    always_comb begin
        n_dist_w   = (r_d_prod + 45'sd8388608) >>> 24;
        n_dist     = n_dist_w[17:0];
        n_abs_beta = r_d_beta < 0 ? 16'(-r_d_beta) : 16'(r_d_beta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= r_d_v;
        end
        r_e_dist    <= n_dist;
        r_e_arrived <= (n_dist < {2'b00, r_distance_margin})
                       && (n_abs_beta < {1'b0, r_heading_margin});
        r_e_pa      <= r_gain_alpha * r_d_alpha;
        r_e_pb      <= r_gain_beta * r_d_beta;
    end

    // stage f: speed product, angle sum
    logic               r_f_v, r_f_arrived;
    logic signed [34:0] r_f_lin;
    logic signed [32:0] r_f_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_e_v;
        end
        r_f_arrived <= r_e_arrived;
        r_f_lin     <= 35'(r_gain_rho) * $signed({17'd0, r_e_dist});
        r_f_sum     <= 33'(r_e_pa) + 33'(r_e_pb);
    end

    // stage g: pi scaling in two partial products, speed rounding
    logic               r_g_v, r_g_arrived;
    logic signed [15:0] r_g_lin;
    logic signed [49:0] r_g_plo;
    logic signed [48:0] r_g_phi;
    logic signed [35:0] n_lin_r;

    assign n_lin_r = (36'(r_f_lin) + 36'sd2048) >>> 12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= r_f_v;
        end
        r_g_arrived <= r_f_arrived;
        r_g_lin     <= sat16(64'(n_lin_r));
        r_g_plo     <= 50'(r_f_sum) * $signed({1'b0, PI_Q29[15:0]});
        r_g_phi     <= 49'(r_f_sum) * $signed({1'b0, PI_Q29[30:16]});
    end

    // stage h: combine, round, saturate, result strobe
    logic signed [65:0] n_total, n_ang_r;

    always_comb begin
        n_total = (66'(r_g_phi) <<< 16) + 66'(r_g_plo);
        n_ang_r = (n_total + (66'sd1 <<< 43)) >>> 44;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_g_v;
        end
        o_arrived      <= r_g_arrived;
        o_linear_speed <= r_g_arrived ? 16'sd0 : r_g_lin;
        o_angular_rate <= r_g_arrived ? 16'sd0 : sat16(n_ang_r[63:0]);
    end

endmodule

/* tb/ppgc_checker.sv */
// checker: predicts controller commands from pose transfers and compares results
`timescale 1ns / 1ps

module ppgc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    input  logic               i_valid,
    input  logic signed [15:0] i_linear_speed,
    input  logic signed [15:0] i_angular_rate,
    input  logic               i_arrived,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ppgc_pkg::*;

    typedef struct {
        logic signed [15:0] speed;
        logic signed [15:0] rate;
        logic               arrived;
    } t_command;

    logic [15:0] ctrl_reg [8];
    t_command    command_queue [$];

    assign o_pending = command_queue.size();

    // clamp to the 16 bit signed range
    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // distance and bearing to goal, then the polar control law
    function automatic t_command control_law(input logic signed [15:0] px,
                                             input logic signed [15:0] py,
                                             input logic signed [15:0] ph);
        t_command           cmd;
        longint             dx, dy, x, y, xs, ys, dist_q8, k_rho, k_alpha, k_beta, v;
        logic [15:0]        z, a;
        logic signed [15:0] bearing, alpha, beta;
        int                 abs_beta;
        dx = longint'($signed(ctrl_reg[REG_GOAL_X])) - longint'(px);
        dy = longint'($signed(ctrl_reg[REG_GOAL_Y])) - longint'(py);
        dist_q8 = 0;
        z = '0;
        if (dx != 0 || dy != 0) begin
            x = dx * 256;
            y = dy * 256;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 16'h8000;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                a = 16'((ATAN_TAB[i] + 32'h8000) >> 16);
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + a;
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - a;
                end
            end
            dist_q8 = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
        end
        bearing = $signed(z);
        alpha = bearing - ph;
        beta = $signed(ctrl_reg[REG_GOAL_HEADING]) - ph;
        abs_beta = (beta < 0) ? -int'(beta) : int'(beta);
        cmd.arrived = (dist_q8 < longint'(ctrl_reg[REG_DISTANCE_MARGIN]))
                      && (abs_beta < int'(ctrl_reg[REG_HEADING_MARGIN]));
        cmd.speed = '0;
        cmd.rate = '0;
        if (!cmd.arrived) begin
            k_rho = $signed(ctrl_reg[REG_GAIN_RHO]);
            k_alpha = $signed(ctrl_reg[REG_GAIN_ALPHA]);
            k_beta = $signed(ctrl_reg[REG_GAIN_BETA]);
            cmd.speed = clamp16((k_rho * dist_q8 + 2048) >>> 12);
            v = (k_alpha * longint'(alpha) + k_beta * longint'(beta)) * 64'sd1686629713;
            cmd.rate = clamp16((v + (64'sd1 <<< 43)) >>> 44);
        end
        return cmd;
    endfunction

    // register copy, pose transfers and result checks
    always @(posedge i_clk) begin
        t_command exp_cmd;
        if (!i_rst_n) begin
            ctrl_reg[REG_GOAL_X]          <= 16'd0;
            ctrl_reg[REG_GOAL_Y]          <= 16'd0;
            ctrl_reg[REG_GOAL_HEADING]    <= 16'd0;
            ctrl_reg[REG_GAIN_RHO]        <= 16'd614;
            ctrl_reg[REG_GAIN_ALPHA]      <= 16'd1638;
            ctrl_reg[REG_GAIN_BETA]       <= 16'hFECD;
            ctrl_reg[REG_DISTANCE_MARGIN] <= 16'd51;
            ctrl_reg[REG_HEADING_MARGIN]  <= 16'd1043;
            command_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ctrl_reg[i_cfg_index] <= (t_reg_idx'(i_cfg_index) == REG_HEADING_MARGIN)
                                         ? {1'b0, i_cfg_data[14:0]} : i_cfg_data;
            end
            if (i_start && !i_busy) begin
                command_queue.push_back(control_law(i_pose_x, i_pose_y, i_pose_heading));
            end
            if (i_valid) begin
                if (command_queue.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result: speed %0d rate %0d arrived %0b",
                                 i_linear_speed, i_angular_rate, i_arrived);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_cmd = command_queue.pop_front();
                    if (exp_cmd.speed !== i_linear_speed || exp_cmd.rate !== i_angular_rate
                        || exp_cmd.arrived !== i_arrived) begin
                        if (o_fail_count < 10) begin
                            $display("result differs: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     exp_cmd.speed, exp_cmd.rate, exp_cmd.arrived,
                                     i_linear_speed, i_angular_rate, i_arrived);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_polar_pose_go_to_goal_controller.sv */
// testbench top: pose stimulus, register phases, watchdog and verdict
`timescale 1ns / 1ps

module tb_polar_pose_go_to_goal_controller;
    import ppgc_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [15:0] i_pose_x;
    logic signed [15:0] i_pose_y;
    logic signed [15:0] i_pose_heading;
    logic               o_valid;
    logic signed [15:0] o_linear_speed;
    logic signed [15:0] o_angular_rate;
    logic               o_arrived;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 burst_left;
    logic [15:0]        setting [8];

    polar_pose_go_to_goal_controller u_top (.*);

    ppgc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_pose_x(i_pose_x), .i_pose_y(i_pose_y), .i_pose_heading(i_pose_heading),
        .i_valid(o_valid), .i_linear_speed(o_linear_speed),
        .i_angular_rate(o_angular_rate), .i_arrived(o_arrived),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("polar_pose_go_to_goal_controller: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one pose transfer, with random gaps between bursts
    task automatic send_pose(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] h);
        int gap;
        i_start        <= 1'b1;
        i_pose_x       <= x;
        i_pose_y       <= y;
        i_pose_heading <= h;
        do @(posedge i_clk); while (o_busy);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // let the pipeline empty before touching registers
    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write every register from the setting array
    task automatic program_setting;
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(t_reg_idx'(k));
            i_cfg_data  <= setting[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // random pose, often close to the goal so arrival gets exercised
    task automatic random_pose;
        logic [15:0] x, y, h;
        if ($urandom_range(0, 9) < 4) begin
            x = setting[REG_GOAL_X] + 16'($urandom_range(0, 160)) - 16'd80;
            y = setting[REG_GOAL_Y] + 16'($urandom_range(0, 160)) - 16'd80;
            h = setting[REG_GOAL_HEADING] + 16'($urandom_range(0, 3000)) - 16'd1500;
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
            h = 16'($urandom);
        end
        send_pose(x, y, h);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_pose_x       = '0;
        i_pose_y       = '0;
        i_pose_heading = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        burst_left     = 5;
        setting = '{16'd0, 16'd0, 16'd0, 16'd614, 16'd1638, 16'hFECD, 16'd51, 16'd1043};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed poses on reset settings
        send_pose(16'd0, 16'd0, 16'd0);          // pose at goal, arrived
        send_pose(16'd10, 16'hFFF6, 16'd500);    // near goal within margins
        send_pose(16'd0, 16'd0, 16'h8000);       // heading error of pi
        send_pose(16'd0, 16'd0, 16'd1043);       // heading margin boundary
        send_pose(16'd51, 16'd0, 16'd0);         // distance margin boundary
        send_pose(16'h7FFF, 16'h7FFF, 16'h7FFF); // goal behind, dx negative
        send_pose(16'h8000, 16'h8000, 16'h8000);
        send_pose(16'h8000, 16'h7FFF, 16'd0);
        send_pose(16'h7FFF, 16'h8000, 16'h4000);
        send_pose(16'd0, 16'h8000, 16'hC000);    // pure y offset
        send_pose(16'hFF00, 16'd0, 16'd0);
        drain;

        // extreme settings, negative rho and beta gains and widest margins
        setting = '{16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                    16'hFFFF, 16'hFFFF};
        program_setting;
        send_pose(16'h8000, 16'h7FFF, 16'h8000);
        send_pose(16'h7FFF, 16'h8000, 16'h0000);
        send_pose(16'h8000, 16'h8000, 16'h7FFF);
        send_pose(16'h7FFF, 16'h7FFF, 16'h8001);
        send_pose(16'd0, 16'd0, 16'd0);
        drain;

        // zero gains and margins, goal heading at its largest
        setting = '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000};
        program_setting;
        send_pose(16'd0, 16'd0, 16'h7FFF);
        send_pose(16'h7FFF, 16'h0000, 16'h8000);
        for (int n = 0; n < 150; n++) random_pose;
        drain;

        // random phases
        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 8; k++) setting[k] = 16'($urandom);
            if (p % 2 == 0) begin
                setting[REG_GAIN_RHO]        = 16'($urandom_range(0, 4096));
                setting[REG_GAIN_ALPHA]      = 16'($urandom_range(0, 4096));
                setting[REG_GAIN_BETA]       = 16'(-$urandom_range(0, 2048));
                setting[REG_DISTANCE_MARGIN] = 16'($urandom_range(0, 200));
                setting[REG_HEADING_MARGIN]  = 16'($urandom_range(0, 3000));
            end
            program_setting;
            setting[REG_HEADING_MARGIN][15] = 1'b0;
            for (int n = 0; n < 165; n++) random_pose;
            drain;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("polar_pose_go_to_goal_controller: match");
        end else begin
            $display("polar_pose_go_to_goal_controller: mismatch");
        end
        $finish;
    end

endmodule
